### hw/rtl/great_circle_bearing_top_macros.svh
// Assertion macros for the great-circle bearing block.
`ifndef GREAT_CIRCLE_BEARING_TOP_MACROS_SVH
`define GREAT_CIRCLE_BEARING_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define GCB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bearing block check failed");

// Check that a condition implies another in the next cycle.
`define GCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bearing block check failed");

`endif

### hw/rtl/gcb_pkg.sv
// Shared types, constants and helper functions for the bearing pipeline.
package gcb_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 20;
    localparam int STAGE_W       = 5;
    localparam int ANG_W         = 26;
    localparam int SC_W          = 20;
    localparam int VEC_W         = 22;
    localparam int LAT_W         = 24;
    localparam int LON_W         = 25;
    localparam int BRG_W         = 25;
    localparam int PIPE_DEPTH    = 2 * CORDIC_STAGES + 4;

    // Configuration register indexes
    localparam logic [1:0] REG_REF_LAT = 2'd0;
    localparam logic [1:0] REG_REF_LON = 2'd1;

    localparam logic signed [ANG_W-1:0] DEG_FULL    = 26'sd23592960;
    localparam logic signed [ANG_W-1:0] DEG_HALF    = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG_QUARTER = 26'sd5898240;
    localparam logic [BRG_W-1:0]        BRG_LIMIT   = 25'd23592960;

    // Start value of the rotation x: floor(K * 2^30) >> 14.
    localparam logic signed [SC_W-1:0]  CORDIC_X0   = 20'sd39796;

    // Rotation CORDIC stage state.
    typedef struct packed {
        logic                    neg;
        logic signed [SC_W-1:0]  x;
        logic signed [SC_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } rot_t;

    // Vectoring CORDIC stage state.
    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } vec_t;

    // Arctangent of 2^-k in degrees, 16 fraction bits.
    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [STAGE_W-1:0] k);
        logic signed [ANG_W-1:0] r;
        begin
            case (k)
                5'd0:    r = 26'sd2949120;
                5'd1:    r = 26'sd1740967;
                5'd2:    r = 26'sd919879;
                5'd3:    r = 26'sd466945;
                5'd4:    r = 26'sd234379;
                5'd5:    r = 26'sd117304;
                5'd6:    r = 26'sd58666;
                5'd7:    r = 26'sd29335;
                5'd8:    r = 26'sd14668;
                5'd9:    r = 26'sd7334;
                5'd10:   r = 26'sd3667;
                5'd11:   r = 26'sd1833;
                5'd12:   r = 26'sd917;
                5'd13:   r = 26'sd458;
                5'd14:   r = 26'sd229;
                5'd15:   r = 26'sd115;
                5'd16:   r = 26'sd57;
                5'd17:   r = 26'sd29;
                5'd18:   r = 26'sd14;
                5'd19:   r = 26'sd7;
                5'd20:   r = 26'sd4;
                5'd21:   r = 26'sd2;
                5'd22:   r = 26'sd1;
                default: r = 26'sd0;
            endcase
            return r;
        end
    endfunction

    // Fold an angle in [-180,180) into [-90,90] and seed the rotation.
    function automatic rot_t fold_angle(input logic signed [ANG_W-1:0] a);
        rot_t r;
        begin
            r.x   = CORDIC_X0;
            r.y   = '0;
            r.neg = 1'b0;
            r.z   = a;
            if (a > DEG_QUARTER)
            begin
                r.z   = a - DEG_HALF;
                r.neg = 1'b1;
            end
            else if (a < -DEG_QUARTER)
            begin
                r.z   = a + DEG_HALF;
                r.neg = 1'b1;
            end
            return r;
        end
    endfunction

endpackage

### hw/rtl/gcb_rot_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation and its register.
module gcb_rot_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gcb_pkg::STAGE_W-1:0]  stage,
    input  gcb_pkg::rot_t                din,
    output gcb_pkg::rot_t                dout
);
    import gcb_pkg::*;

    logic signed [SC_W-1:0] dx;
    logic signed [SC_W-1:0] dy;
    rot_t                   cell_next;
    rot_t                   cell_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        dx            = din.y >>> stage;
        dy            = din.x >>> stage;
        cell_next.neg = din.neg;
        if (!din.z[ANG_W-1])
        begin
            cell_next.x = din.x - dx;
            cell_next.y = din.y + dy;
            cell_next.z = din.z - atan_deg(stage);
        end
        else
        begin
            cell_next.x = din.x + dx;
            cell_next.y = din.y - dy;
            cell_next.z = din.z + atan_deg(stage);
        end
    end

    // Advance when the pipeline moves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### hw/rtl/gcb_vec_cell.sv
// One vectoring-mode CORDIC cell: a single micro-rotation and its register.
module gcb_vec_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gcb_pkg::STAGE_W-1:0]  stage,
    input  gcb_pkg::vec_t                din,
    output gcb_pkg::vec_t                dout
);
    import gcb_pkg::*;

    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    vec_t                    cell_next;
    vec_t                    cell_reg;

    // Rotate the vector onto the positive x axis
    always_comb
    begin
        dx             = din.y >>> stage;
        dy             = din.x >>> stage;
        cell_next.zero = din.zero;
        if (din.y > 0)
        begin
            cell_next.x = din.x + dx;
            cell_next.y = din.y - dy;
            cell_next.z = din.z + atan_deg(stage);
        end
        else
        begin
            cell_next.x = din.x - dx;
            cell_next.y = din.y + dy;
            cell_next.z = din.z - atan_deg(stage);
        end
    end

    // Advance when the pipeline moves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### hw/rtl/great_circle_bearing_top.sv
// Top level of the great-circle initial bearing pipeline.
// The block takes one target position per clock when not stalled and returns its initial
// bearing from the configured reference position: one input register, three parallel rows of
// 20 rotation CORDIC cells for the sines and cosines, two multiply stages, one setup stage
// and a row of 20 vectoring CORDIC cells for atan2. The row length of the CORDIC cells sets
// the latency; throughput is one item per cycle unless stalled. A two-entry output buffer
// keeps accepting items while a finished bearing waits; input stall rises only when both
// entries are full. Write ref_lat and ref_lon only while no item is in flight.
`include "great_circle_bearing_top_macros.svh"

module great_circle_bearing_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gcb_pkg::LAT_W-1:0]    target_lat,
    input  logic signed [gcb_pkg::LON_W-1:0]    target_lon,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gcb_pkg::BRG_W-1:0]           bearing,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [gcb_pkg::LON_W-1:0]           cfg_data
);
    import gcb_pkg::*;

    localparam int ROT_END = CORDIC_STAGES;
    localparam int LAST    = PIPE_DEPTH - 1;

    logic signed [LAT_W-1:0]  ref_lat_reg;
    logic signed [LON_W-1:0]  ref_lon_reg;

    logic                     en;
    logic [PIPE_DEPTH-1:0]    pipe_vld_reg;

    logic signed [ANG_W-1:0]  dlon_raw;
    logic signed [ANG_W-1:0]  dlon_next;
    logic signed [ANG_W-1:0]  lat1_reg;
    logic signed [ANG_W-1:0]  lat2_reg;
    logic signed [ANG_W-1:0]  dlon_reg;

    rot_t                     lat1_ch [0:CORDIC_STAGES];
    rot_t                     lat2_ch [0:CORDIC_STAGES];
    rot_t                     dlon_ch [0:CORDIC_STAGES];
    vec_t                     vec_ch  [0:CORDIC_STAGES];

    logic signed [SC_W-1:0]   s1;
    logic signed [SC_W-1:0]   c1;
    logic signed [SC_W-1:0]   s2;
    logic signed [SC_W-1:0]   c2;
    logic signed [SC_W-1:0]   sd;
    logic signed [SC_W-1:0]   cd;

    logic signed [2*SC_W-1:0] py_prod;
    logic signed [2*SC_W-1:0] pa_prod;
    logic signed [2*SC_W-1:0] pb_prod;
    logic signed [VEC_W-1:0]  py_reg;
    logic signed [VEC_W-1:0]  pa_reg;
    logic signed [SC_W-1:0]   pb_reg;
    logic signed [SC_W-1:0]   cd_reg;

    logic signed [2*SC_W-1:0] pc_prod;
    logic signed [VEC_W-1:0]  vx_next;
    logic signed [VEC_W-1:0]  vx_reg;
    logic signed [VEC_W-1:0]  vy_reg;

    vec_t                     vset_next;
    vec_t                     vset_reg;

    logic signed [ANG_W-1:0]  z_end;
    logic signed [ANG_W-1:0]  brg_wide;
    logic [BRG_W-1:0]         brg_next;
    logic                     push;
    logic                     pop;
    logic                     out_valid_reg;
    logic [BRG_W-1:0]         out_reg;
    logic                     skid_valid_reg;
    logic [BRG_W-1:0]         skid_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= 24'sd2006983;
            ref_lon_reg <= -25'sd6313984;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REF_LAT: ref_lat_reg <= cfg_data[LAT_W-1:0];
                REG_REF_LON: ref_lon_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output buffer is full
    assign en       = !skid_valid_reg;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
        end
        else if (en)
        begin
            pipe_vld_reg <= {pipe_vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // Form dlon and wrap it into [-180,180)
    always_comb
    begin
        dlon_raw = ANG_W'(target_lon) - ANG_W'(ref_lon_reg);
        if (dlon_raw >= DEG_HALF)
        begin
            dlon_next = dlon_raw - DEG_FULL;
        end
        else if (dlon_raw < -DEG_HALF)
        begin
            dlon_next = dlon_raw + DEG_FULL;
        end
        else
        begin
            dlon_next = dlon_raw;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= ANG_W'(ref_lat_reg);
            lat2_reg <= ANG_W'(target_lat);
            dlon_reg <= dlon_next;
        end
    end

    // Seed the three rotation rows
    assign lat1_ch[0] = fold_angle(lat1_reg);
    assign lat2_ch[0] = fold_angle(lat2_reg);
    assign dlon_ch[0] = fold_angle(dlon_reg);

    // Rotation rows for sine and cosine
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        gcb_rot_cell u_lat1 (
            .clk   (clk),
            .en    (en),
            .stage (STAGE_W'(i)),
            .din   (lat1_ch[i]),
            .dout  (lat1_ch[i+1])
        );
        gcb_rot_cell u_lat2 (
            .clk   (clk),
            .en    (en),
            .stage (STAGE_W'(i)),
            .din   (lat2_ch[i]),
            .dout  (lat2_ch[i+1])
        );
        gcb_rot_cell u_dlon (
            .clk   (clk),
            .en    (en),
            .stage (STAGE_W'(i)),
            .din   (dlon_ch[i]),
            .dout  (dlon_ch[i+1])
        );
    end

    // Undo the half-turn fold
    always_comb
    begin
        s1 = lat1_ch[ROT_END].neg ? -lat1_ch[ROT_END].y : lat1_ch[ROT_END].y;
        c1 = lat1_ch[ROT_END].neg ? -lat1_ch[ROT_END].x : lat1_ch[ROT_END].x;
        s2 = lat2_ch[ROT_END].neg ? -lat2_ch[ROT_END].y : lat2_ch[ROT_END].y;
        c2 = lat2_ch[ROT_END].neg ? -lat2_ch[ROT_END].x : lat2_ch[ROT_END].x;
        sd = dlon_ch[ROT_END].neg ? -dlon_ch[ROT_END].y : dlon_ch[ROT_END].y;
        cd = dlon_ch[ROT_END].neg ? -dlon_ch[ROT_END].x : dlon_ch[ROT_END].x;
    end

    // First multiply stage
    assign py_prod = sd * c2;
    assign pa_prod = c1 * s2;
    assign pb_prod = s1 * c2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg <= VEC_W'(py_prod >>> FRAC_BITS);
            pa_reg <= VEC_W'(pa_prod >>> FRAC_BITS);
            pb_reg <= SC_W'(pb_prod >>> FRAC_BITS);
            cd_reg <= cd;
        end
    end

    // Second multiply stage and the x difference
    assign pc_prod = pb_reg * cd_reg;
    assign vx_next = pa_reg - VEC_W'(pc_prod >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg <= vx_next;
            vy_reg <= py_reg;
        end
    end

    // Move the vector into the right half plane
    always_comb
    begin
        vset_next.zero = (vx_reg == '0) && (vy_reg == '0);
        vset_next.x    = vx_reg;
        vset_next.y    = vy_reg;
        vset_next.z    = '0;
        if (vx_reg[VEC_W-1])
        begin
            vset_next.x = -vx_reg;
            vset_next.y = -vy_reg;
            vset_next.z = vy_reg[VEC_W-1] ? -DEG_HALF : DEG_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vset_reg <= vset_next;
        end
    end

    assign vec_ch[0] = vset_reg;

    // Vectoring row for atan2
    for (genvar j = 0; j < CORDIC_STAGES; j++)
    begin : g_vec
        gcb_vec_cell u_vec (
            .clk   (clk),
            .en    (en),
            .stage (STAGE_W'(j)),
            .din   (vec_ch[j]),
            .dout  (vec_ch[j+1])
        );
    end

    // Normalize into [0,360)
    always_comb
    begin
        z_end    = vec_ch[CORDIC_STAGES].z;
        brg_wide = z_end[ANG_W-1] ? (z_end + DEG_FULL) : z_end;
        brg_next = vec_ch[CORDIC_STAGES].zero ? '0 : brg_wide[BRG_W-1:0];
    end

    // Two-entry output buffer
    assign push = en && pipe_vld_reg[LAST];
    assign pop  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg  <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= brg_next;
            end
            else
            begin
                out_reg  <= brg_next;
            end
        end
        else if (push)
        begin
            skid_reg <= brg_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bearing   = out_reg;

    // Checks on the buffer and pipeline entry
    `GCB_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `GCB_ASSERT_SAME(a_bearing_range, out_valid_reg, bearing < BRG_LIMIT)
    `GCB_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, pipe_vld_reg[0])

endmodule

### test/testbench.sv
// Self-checking testbench for the great-circle initial bearing block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gcb_pkg::*;

    localparam int          LATENCY    = 2 * CORDIC_STAGES + 4;
    localparam int          STAGES     = 20;
    localparam int          NUM_RANDOM = 450;
    localparam logic [1:0]  IDX_SPARE  = 2'd2;
    localparam longint      FULL       = 64'sd23592960;
    localparam longint      HALF       = 64'sd11796480;
    localparam longint      QUARTER    = 64'sd5898240;
    localparam longint      LAT_MAX    = 64'sd5898240;
    localparam longint      LON_MAX    = 64'sd11796480;
    localparam longint      NO_RESULT  = -1;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [LAT_W-1:0] target_lat;
    logic signed [LON_W-1:0] target_lon;
    logic                    out_valid;
    logic                    out_stall;
    logic [BRG_W-1:0]        bearing;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [LON_W-1:0]        cfg_data;

    // Predictor copy of the reference position
    logic [LAT_W-1:0] home_lat;
    logic [LON_W-1:0] home_lon;

    longint bearing_queue[$];
    int     mismatches;
    int     bearings_seen;
    int     fixes_sent;
    int     hold_cycles;
    bit     hold_on;

    longint arctan_deg[32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    great_circle_bearing_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .target_lat (target_lat),
        .target_lon (target_lon),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bearing    (bearing),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    initial
    begin
        #20ms;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    // Wrap an angle into [-180,180) degrees
    function automatic longint wrap_half(input longint a);
        longint r;
        r = a % FULL;
        if (r < 0)
            r += FULL;
        if (r >= HALF)
            r -= FULL;
        return r;
    endfunction

    // Rotation CORDIC in degrees, returns sine and cosine
    function automatic void rotate_deg(input longint ang, output longint s, output longint c);
        longint a, x, y, z, dx, dy;
        bit     flip;
        a = wrap_half(ang);
        flip = 0;
        if (a > QUARTER)
        begin
            a -= HALF;
            flip = 1;
        end
        else if (a < -QUARTER)
        begin
            a += HALF;
            flip = 1;
        end
        x = 64'sd652032874 >>> (30 - 16);
        y = 0;
        z = a;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_deg[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_deg[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // Vectoring CORDIC atan2 in degrees
    function automatic longint vector_deg(input longint yi, input longint xi);
        longint x, y, z, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? HALF : -HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += arctan_deg[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arctan_deg[i];
            end
        end
        return z;
    endfunction

    // Predict the bearing to one target
    function automatic longint predict_bearing(input logic [LAT_W-1:0] lat2,
                                               input logic [LON_W-1:0] lon2);
        longint s1, c1, s2, c2, sd, cd, y, x, b;
        rotate_deg(longint'($signed(home_lat)), s1, c1);
        rotate_deg(longint'($signed(lat2)), s2, c2);
        rotate_deg(longint'($signed(lon2)) - longint'($signed(home_lon)), sd, cd);
        y = (sd * c2) >>> 16;
        x = ((c1 * s2) >>> 16) - ((((s1 * c2) >>> 16) * cd) >>> 16);
        b = vector_deg(y, x) % FULL;
        if (b < 0)
            b += FULL;
        return b & 64'h1FFFFFF;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check every accepted bearing against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            bearings_seen++;
            if (bearing_queue.size() == 0)
                report_mismatch("unexpected bearing", longint'(bearing), NO_RESULT);
            else
            begin
                longint want;
                want = bearing_queue.pop_front();
                if (longint'(bearing) != want)
                    report_mismatch("bearing", longint'(bearing), want);
            end
        end
    end

    // Receiver stall: random waits per item, or a long hold-off
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_on)
            begin
                out_stall <= 1'b1;
                hold_cycles++;
            end
            else if (out_stall)
            begin
                out_stall <= 1'b0;
            end
            else if (out_valid)
            begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                if (wait_n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_n - 1)
                        @(negedge clk);
                end
            end
        end
    end

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [LON_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_REF_LAT)
            home_lat = val[LAT_W-1:0];
        else if (idx == REG_REF_LON)
            home_lon = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one target, hold it until accepted
    task automatic send_fix(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                            input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        target_lat <= lat;
        target_lon <= lon;
        do
            @(posedge clk);
        while (in_stall);
        bearing_queue.push_back(predict_bearing(lat, lon));
        fixes_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (bearing_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8)
            @(posedge clk);
    endtask

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Directed rows: lat, lon, known bearing or NO_RESULT for predictor check
    typedef struct {
        longint lat;
        longint lon;
        longint known;
    } fix_row_t;

    fix_row_t rows[] = '{
        '{64'sd2006983, -64'sd6313984, NO_RESULT},
        '{LAT_MAX, 0, NO_RESULT},
        '{-LAT_MAX, 0, NO_RESULT},
        '{0, LON_MAX, NO_RESULT},
        '{0, -LON_MAX, NO_RESULT},
        '{LAT_MAX, LON_MAX, NO_RESULT},
        '{-LAT_MAX, -LON_MAX, NO_RESULT},
        '{64'sd8388607, 64'sd16777215, NO_RESULT},
        '{-64'sd8388608, -64'sd16777216, NO_RESULT},
        '{-1, -1, NO_RESULT},
        '{0, 0, NO_RESULT},
        '{64'sd2006983, -64'sd6313984 + HALF, NO_RESULT},
        '{-64'sd2006983, -64'sd6313984 + HALF, NO_RESULT},
        '{64'sd2006983, -64'sd6313983, NO_RESULT},
        '{64'sd2006984, -64'sd6313984, NO_RESULT}
    };

    initial
    begin
        longint lat_lim, lon_lim;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        target_lat = '0;
        target_lon = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_REF_LAT;
        cfg_data   = '0;
        hold_on    = 0;
        home_lat   = 24'(2006983);
        home_lon   = 25'(-6313984);
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table with reset reference
        foreach (rows[i])
        begin
            send_fix(rows[i].lat[LAT_W-1:0], rows[i].lon[LON_W-1:0], $urandom_range(0, 2));
            if (rows[i].known != NO_RESULT)
            begin
                bearing_queue[bearing_queue.size()-1] = rows[i].known;
            end
        end
        drain();

        // Ignored spare index, then reference at the poles and dateline
        write_reg(IDX_SPARE, 25'h1555555);
        write_reg(REG_REF_LAT, 25'(LAT_MAX));
        write_reg(REG_REF_LON, 25'(LON_MAX));
        send_fix(24'(LAT_MAX), 25'(LON_MAX), 0);
        send_fix(24'(-LAT_MAX), 25'(-LON_MAX), 0);
        send_fix(24'(0), 25'(0), 0);
        drain();
        write_reg(IDX_SPARE, 25'h0AAAAAA);
        write_reg(REG_REF_LAT, 25'(-LAT_MAX));
        write_reg(REG_REF_LON, 25'(-LON_MAX));
        send_fix(24'(LAT_MAX), 25'(LON_MAX), 0);
        send_fix(24'(-LAT_MAX), 25'(0), 0);
        drain();

        // Random phases over several reference positions
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_REF_LAT, 25'(rand_span(LAT_MAX)));
            write_reg(REG_REF_LON, 25'(rand_span(LON_MAX)));
            for (int n = 0; n < NUM_RANDOM / 5; n++)
            begin
                lat_lim = ($urandom_range(0, 9) == 0) ? 64'sd8388607 : LAT_MAX;
                lon_lim = ($urandom_range(0, 9) == 0) ? 64'sd16777215 : LON_MAX;
                // Long receiver hold-off so the block fills and stalls its input
                if (phase == 1 && n == 10)
                begin
                    hold_on = 1;
                    fork
                        begin
                            while (hold_cycles < 120)
                                @(posedge clk);
                            hold_on = 0;
                        end
                    join_none
                end
                // Sender pause until all bearings are back
                if (phase == 3 && n == 40)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (bearing_queue.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(0, 15) == 0)
                    send_fix(24'($urandom), 25'($urandom), 0);
                else
                    send_fix(24'(rand_span(lat_lim)), 25'(rand_span(lon_lim)),
                             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5));
            end
            drain();
        end

        $display("Sent %0d targets over 8 reference settings, %0d bearings checked.",
                 fixes_sent, bearings_seen);
        $display("Covered field extremes, antipodal and coincident points, full backpressure.");
        if (mismatches == 0 && bearing_queue.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
